[rtl/wmf_pkg.sv]
// wmf_pkg: shared types and constants of the windowed median filter
// depends on nothing; imported by windowed_median_filter, wmf_checker and the testbench
`default_nettype none

package wmf_pkg;

  localparam int MAX_RADIUS  = 7;
  localparam int SAMPLE_BITS = 16;
  localparam int DEPTH       = 2 * MAX_RADIUS + 1;
  localparam int RADIUS_W    = 3;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int STEP_W      = $clog2(SAMPLE_BITS);
  localparam int POS_W       = $clog2(MAX_RADIUS + 1);

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(3);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          first;
    logic                          last;
  } sample_req_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] median_value;
    logic                          series_end;
  } median_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_BITS,
    ST_DONE
  } wmf_state_e;

endpackage

`default_nettype wire

[rtl/windowed_median_filter.sv]
// windowed_median_filter: centered median over a series with cut-short edges
// depends on wmf_pkg (types, constants, state enum)
`default_nettype none

//  channel   direction  handshake                     payload
//  in        request    in_valid_i / in_stall_o       in_req_i  (sample_req_t)
//  out       result     out_valid_o / out_stall_i     out_res_o (median_res_t)
//  cfg       write      cfg_we_i                      cfg_wdata_i (radius)
//
//  a request is taken in an idle cycle; each median then loads the window copy,
//  takes one selection step per bit msb first and hands off, so a request with a
//  median keeps the sequencer busy, while one without leaves it idle
//  a last request gives one median per flushed position, up to MAX_RADIUS + 1
//  requests stall until the sequencer is idle; a stalled result holds the hand-off
//  reset clears control state and sets radius to 3; the window is not cleared

module windowed_median_filter (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire wmf_pkg::sample_req_t          in_req_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      wmf_pkg::median_res_t          out_res_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [wmf_pkg::RADIUS_W-1:0]  cfg_wdata_i
);
  import wmf_pkg::*;

  // control state
  wmf_state_e           state_q, state_d;
  logic [RADIUS_W-1:0]  radius_q;
  logic [CNT_W-1:0]     held_q, held_d;
  logic                 in_series_q, in_series_d;
  logic [CNT_W-1:0]     lim_q, lim_d;       // index of the oldest sample still in the series
  logic [POS_W-1:0]     pos_q, pos_d;       // center offset from newest sample
  logic                 flush_q, flush_d;
  logic [STEP_W-1:0]    step_q;
  logic                 out_valid_q, out_valid_d;

  // datapath
  logic [SAMPLE_BITS-1:0] win_q  [DEPTH];   // sample shift line, newest at 0
  logic [SAMPLE_BITS-1:0] work_q [DEPTH];   // copy that shifts left one bit a cycle while selecting
  logic [DEPTH-1:0]       cand_q;           // entries still matching the prefix
  logic [CNT_W-1:0]       rank_q;           // rank left to find among candidates
  logic [SAMPLE_BITS-1:0] res_q;
  median_res_t            out_res_q;

  logic                   accept;
  logic                   out_free;
  logic [RADIUS_W-1:0]    r_eff;
  logic [POS_W-1:0]       r_pos;
  logic [CNT_W-1:0]       held_base, held_new, lim_new;
  logic                   start_one;
  logic [CNT_W-1:0]       span_sum, hi_idx, rank_init;
  logic [DEPTH-1:0]       win_mask;
  logic [DEPTH-1:0]       key_bits, zero_cand;
  logic [CNT_W-1:0]       zero_cnt;
  logic                   is_msb, pick_one;
  logic                   last_step;

  // radius clamp to the store size
  assign r_eff = (radius_q > RADIUS_W'(MAX_RADIUS)) ? RADIUS_W'(MAX_RADIUS) : radius_q;
  assign r_pos = POS_W'(r_eff);

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // series bookkeeping on a new request
  assign held_base = (in_req_i.first || !in_series_q) ? '0 : held_q;
  assign held_new  = (held_base == CNT_W'(DEPTH)) ? held_base : held_base + 1'b1;
  assign lim_new   = held_new - 1'b1;
  assign start_one = (CNT_W'(r_eff) <= lim_new);

  // window of the current center: entries 0 .. min(pos + r, lim)
  // (center never exceeds radius, so the low end is always the newest sample)
  assign span_sum  = CNT_W'(pos_q) + CNT_W'(r_eff);
  assign hi_idx    = (span_sum > lim_q) ? lim_q : span_sum;
  assign rank_init = CNT_W'((hi_idx + 1'b1) >> 1);   // upper median

  always_comb begin
    for (int a = 0; a < DEPTH; a++) begin
      win_mask[a] = (CNT_W'(a) <= hi_idx);
    end
  end

  // one selection step: the sign bit is inverted so negatives sort low
  assign is_msb    = (step_q == '0);
  assign last_step = (step_q == STEP_W'(SAMPLE_BITS - 1));

  always_comb begin
    for (int a = 0; a < DEPTH; a++) begin
      key_bits[a] = work_q[a][SAMPLE_BITS-1] ^ is_msb;
    end
  end

  assign zero_cand = cand_q & ~key_bits;

  always_comb begin
    zero_cnt = '0;
    for (int a = 0; a < DEPTH; a++) begin
      zero_cnt = zero_cnt + CNT_W'(zero_cand[a]);
    end
  end

  // target lies among the ones once the zeros cannot cover its rank
  assign pick_one = (rank_q >= zero_cnt);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (in_req_i.last || start_one)) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: state_d = ST_BITS;
      ST_BITS: begin
        if (last_step) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = (flush_q && (pos_q != '0)) ? ST_LOAD : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs and bookkeeping
  always_comb begin
    held_d      = held_q;
    in_series_d = in_series_q;
    lim_d       = lim_q;
    pos_d       = pos_q;
    flush_d     = flush_q;
    out_valid_d = out_valid_q && out_stall_i;
    in_stall_o  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (accept) begin
          lim_d   = lim_new;
          flush_d = in_req_i.last;
          if (in_req_i.last) begin
            // flush starts at the nearer of radius and series start
            pos_d       = (CNT_W'(r_eff) < lim_new) ? r_pos : POS_W'(lim_new);
            held_d      = '0;
            in_series_d = 1'b0;
          end else begin
            pos_d       = r_pos;
            held_d      = held_new;
            in_series_d = 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (flush_q && (pos_q != '0)) begin
            pos_d = pos_q - 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      radius_q    <= RADIUS_RESET;
      held_q      <= '0;
      in_series_q <= 1'b0;
      lim_q       <= '0;
      pos_q       <= '0;
      flush_q     <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      in_series_q <= in_series_d;
      lim_q       <= lim_d;
      pos_q       <= pos_d;
      flush_q     <= flush_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        radius_q <= cfg_wdata_i;
      end
      if (state_q == ST_BITS) begin
        step_q <= step_q + 1'b1;
      end else begin
        step_q <= '0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      win_q[0] <= in_req_i.sample;
      for (int a = 1; a < DEPTH; a++) begin
        win_q[a] <= win_q[a-1];
      end
    end
    case (state_q)
      ST_LOAD: begin
        for (int a = 0; a < DEPTH; a++) begin
          work_q[a] <= win_q[a];
        end
        cand_q <= win_mask;
        rank_q <= rank_init;
      end
      ST_BITS: begin
        for (int a = 0; a < DEPTH; a++) begin
          work_q[a] <= {work_q[a][SAMPLE_BITS-2:0], 1'b0};
        end
        if (pick_one) begin
          cand_q <= cand_q & key_bits;
          rank_q <= rank_q - zero_cnt;
        end else begin
          cand_q <= zero_cand;
        end
        res_q <= {res_q[SAMPLE_BITS-2:0], pick_one ^ is_msb};
      end
      ST_DONE: begin
        if (out_free) begin
          out_res_q.median_value <= res_q;
          out_res_q.series_end   <= flush_q && (pos_q == '0);
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

`default_nettype wire

[rtl/wmf_checker.sv]
// wmf_checker: port-level checks of windowed_median_filter, bound to every instance of it
// depends on wmf_pkg and windowed_median_filter
`default_nettype none

module wmf_checker (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_stall_o,
  input wire wmf_pkg::sample_req_t  in_req_i,
  input wire logic                  out_valid_o,
  input wire logic                  out_stall_i,
  input wire wmf_pkg::median_res_t  out_res_o
);
  import wmf_pkg::*;

  // stalled result stays up and unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_res_o))
    else $error("stalled result dropped or changed");

  // a last request always starts a flush, so the request side stalls next
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_req_i.last |=> in_stall_o)
    else $error("last request did not start a flush");

  // a median needs the serial pass, never rises in the cycle after a request is taken
  a_no_fast_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result appeared too early");

  // no request taken straight after a last request, while its flush keeps the sequencer busy
  a_busy_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_req_i.last |=> !(in_valid_i && !in_stall_o))
    else $error("request taken during flush");

endmodule

bind windowed_median_filter wmf_checker u_wmf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_res_o   (out_res_o)
);

`default_nettype wire

[test/windowed_median_filter_tb.sv]
// windowed_median_filter_tb: self-checking bench for the windowed median filter
// drives directed rows then random series through the request and cfg channels,
// checks medians against a window model or typed values; needs wmf_pkg, filter rtl
`timescale 1ns / 100ps

module windowed_median_filter_tb;
  import wmf_pkg::*;

  // idle time after the last median before the block counts as quiet:
  // long enough for two full selection passes
  localparam int SETTLE_CYCLES = 2 * (SAMPLE_BITS + 2) + 4;
  // cycles with no transfer on either channel before the run is abandoned
  localparam int QUIET_LIMIT   = 2000;
  localparam int NUM_PHASES    = 5;
  localparam int PHASE_ITEMS   = 40;
  // marks a directed row whose medians come from the window model
  localparam int CHECK_PRED    = -1;

  typedef enum logic {
    ROW_REQ,
    ROW_CFG
  } row_kind_e;

  // one directed row: a request or a radius write; for ROW_CFG value is the radius
  typedef struct {
    row_kind_e kind;
    int        value;
    bit        first;
    bit        last;
    int        typed_n;
    int        typed_median;
    bit        typed_end;
  } stim_row_t;

  localparam int NUM_DIRECTED = 24;

  // radius starts at its reset value of 3
  stim_row_t directed_rows [NUM_DIRECTED] = '{
    // no series open after reset: a plain sample opens one, too early for a median
    '{ROW_REQ,      5, 0, 0, 0,               0, 0},
    '{ROW_REQ,    100, 0, 0, CHECK_PRED,      0, 0},
    '{ROW_REQ,     -3, 0, 0, CHECK_PRED,      0, 0},
    '{ROW_REQ,      7, 0, 0, CHECK_PRED,      0, 0},
    '{ROW_REQ,  32767, 0, 0, CHECK_PRED,      0, 0},
    // first inside an open series drops it without a flush
    '{ROW_REQ,      9, 1, 0, CHECK_PRED,      0, 0},
    // two-sample series, shorter than the radius, flushed by last
    '{ROW_REQ, -32768, 0, 1, CHECK_PRED,      0, 0},
    // one-sample series give the sample back, marked as the series end
    '{ROW_REQ,  32767, 1, 1, 1,           32767, 1},
    '{ROW_REQ, -32768, 1, 1, 1,          -32768, 1},
    '{ROW_REQ,      0, 1, 1, 1,               0, 1},
    '{ROW_REQ,     77, 0, 1, 1,              77, 1},
    // radius 0: every median is the sample itself
    '{ROW_CFG,      0, 0, 0, 0,               0, 0},
    '{ROW_REQ,     -1, 1, 0, 1,              -1, 0},
    '{ROW_REQ,     42, 0, 0, 1,              42, 0},
    // radius raised to its maximum inside the open series
    '{ROW_CFG,      7, 0, 0, 0,               0, 0},
    '{ROW_REQ,      1, 0, 0, CHECK_PRED,      0, 0},
    '{ROW_REQ,     -5, 0, 0, CHECK_PRED,      0, 0},
    '{ROW_REQ,    300, 0, 0, CHECK_PRED,      0, 0},
    '{ROW_REQ, -32768, 0, 0, CHECK_PRED,      0, 0},
    '{ROW_REQ,  32767, 0, 0, CHECK_PRED,      0, 0},
    '{ROW_REQ,      2, 0, 0, CHECK_PRED,      0, 0},
    // radius lowered again mid series, then flushed
    '{ROW_CFG,      2, 0, 0, 0,               0, 0},
    '{ROW_REQ,     11, 0, 0, CHECK_PRED,      0, 0},
    '{ROW_REQ,    -11, 0, 1, CHECK_PRED,      0, 0}
  };

  // random phases: radius, sender idle percent, receiver stall percent
  localparam int PHASE_RADIUS [NUM_PHASES] = '{4, 7, 0, 2, 6};
  localparam int PHASE_IDLE   [NUM_PHASES] = '{0, 56, 0, 28, 0};
  localparam int PHASE_STALL  [NUM_PHASES] = '{0, 0, 56, 28, 0};

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  sample_req_t           in_req_i    = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  median_res_t           out_res_o;
  logic                  cfg_we_i    = 1'b0;
  logic [RADIUS_W-1:0]   cfg_wdata_i = '0;

  windowed_median_filter uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // window model state, kept apart from the block
  logic signed [SAMPLE_BITS-1:0] window_samples [DEPTH];
  int                            held_samples  = 0;
  bit                            series_open   = 1'b0;
  logic [RADIUS_W-1:0]           radius_q      = RADIUS_RESET;

  median_res_t step_medians [$];     // medians caused by the request just taken
  median_res_t pending_medians [$];  // medians still owed by the block, oldest first

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int mismatches    = 0;
  int quiet_cycles  = 0;
  int series_left   = 0;

  // median of the held samples within r of offset ctr (0 = newest)
  function automatic logic signed [SAMPLE_BITS-1:0] window_median(input int ctr, input int r);
    logic signed [SAMPLE_BITS-1:0] sorted [DEPTH];
    logic signed [SAMPLE_BITS-1:0] v;
    int lo;
    int hi;
    int n;
    int b;
    lo = (ctr > r) ? ctr - r : 0;
    hi = ctr + r;
    if (hi > held_samples - 1) hi = held_samples - 1;
    n = 0;
    for (int a = lo; a <= hi && a < DEPTH; a++) begin
      // insertion sort, ascending
      v = window_samples[a];
      b = n;
      while (b > 0 && sorted[b-1] > v) begin
        sorted[b] = sorted[b-1];
        b--;
      end
      sorted[b] = v;
      n++;
    end
    // upper median on an even count
    return sorted[n / 2];
  endfunction

  // advance the window model by one request and collect its medians
  function automatic void predict_request(input sample_req_t req);
    median_res_t res;
    int r;
    int d;
    step_medians.delete();
    r = (radius_q > MAX_RADIUS) ? MAX_RADIUS : int'(radius_q);
    if (req.first || !series_open) begin
      held_samples = 0;
      series_open  = 1'b1;
    end
    for (int k = DEPTH - 1; k > 0; k--) window_samples[k] = window_samples[k-1];
    window_samples[0] = req.sample;
    if (held_samples < DEPTH) held_samples++;
    if (!req.last) begin
      // center lags the newest sample by the radius
      if (r <= held_samples - 1) begin
        res.median_value = window_median(r, r);
        res.series_end   = 1'b0;
        step_medians.push_back(res);
      end
    end else begin
      // flush every position still owed, oldest first, down to the newest
      d = (r < held_samples - 1) ? r : held_samples - 1;
      while (d >= 0) begin
        res.median_value = window_median(d, r);
        res.series_end   = (d == 0);
        step_medians.push_back(res);
        d--;
      end
      held_samples = 0;
      series_open  = 1'b0;
    end
  endfunction

  // present one request, hold it until taken, then log the medians it owes
  task automatic send_request(input sample_req_t req, input int typed_n,
                              input median_res_t typed_res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_request(req);
    if (typed_n == CHECK_PRED) begin
      foreach (step_medians[i]) pending_medians.push_back(step_medians[i]);
    end else if (typed_n == 1) begin
      pending_medians.push_back(typed_res);
    end
  endtask

  // hold the sender until every owed median is out and the block has settled
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (pending_medians.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // radius writes only land while the block is quiet
  task automatic write_radius(input int value);
    wait_quiet();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= RADIUS_W'(value);
    @(posedge clk_i);
    radius_q = RADIUS_W'(value);
    cfg_we_i <= 1'b0;
  endtask

  // mix of full-range, near-zero ties, extremes and mid-range samples
  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    int pick;
    pick = $urandom_range(3);
    case (pick)
      0: return SAMPLE_BITS'($urandom);
      1: return SAMPLE_BITS'(int'($urandom_range(8)) - 4);
      2: begin
        case ($urandom_range(3))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return SAMPLE_BITS'(int'($urandom_range(2000)) - 1000);
    endcase
  endfunction

  // receiver stall, redrawn every cycle
  always @(posedge clk_i) begin
    out_stall_i <= rst_ni && ($urandom_range(99) < stall_pct);
  end

  // result check, field by field against the oldest owed median
  always @(posedge clk_i) begin : median_check
    median_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_medians.size() == 0) begin
        $display("%0t: unexpected median, expected none, actual %0d end %0b",
                 $time, out_res_o.median_value, out_res_o.series_end);
        mismatches++;
      end else begin
        want = pending_medians.pop_front();
        if (out_res_o.median_value !== want.median_value) begin
          $display("%0t: median_value mismatch, expected %0d, actual %0d",
                   $time, want.median_value, out_res_o.median_value);
          mismatches++;
        end
        if (out_res_o.series_end !== want.series_end) begin
          $display("%0t: series_end mismatch, expected %0b, actual %0b",
                   $time, want.series_end, out_res_o.series_end);
          mismatches++;
        end
      end
    end
  end

  // watchdog: any transfer on either channel counts as progress
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    sample_req_t req;
    median_res_t typed_res;
    foreach (window_samples[i]) window_samples[i] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed rows
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_radius(directed_rows[i].value);
      end else begin
        req.sample             = SAMPLE_BITS'(directed_rows[i].value);
        req.first              = directed_rows[i].first;
        req.last               = directed_rows[i].last;
        typed_res.median_value = SAMPLE_BITS'(directed_rows[i].typed_median);
        typed_res.series_end   = directed_rows[i].typed_end;
        send_request(req, directed_rows[i].typed_n, typed_res);
      end
    end

    // random series; an open series runs on across phases, so the radius
    // also changes mid series there
    typed_res = '0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_radius(PHASE_RADIUS[p]);
      send_idle_pct = PHASE_IDLE[p];
      stall_pct     = PHASE_STALL[p];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        req.sample = pick_sample();
        if (series_left == 0) begin
          series_left = ($urandom_range(7) == 0) ? $urandom_range(1, 3)
                                                 : $urandom_range(1, 20);
          // now and then a series opens without its first marker
          req.first = ($urandom_range(11) != 0);
        end else begin
          // stray first inside a series drops what was held
          req.first = ($urandom_range(15) == 0);
        end
        req.last = (series_left == 1);
        series_left--;
        send_request(req, CHECK_PRED, typed_res);
      end
    end

    wait_quiet();
    send_idle_pct = 0;
    stall_pct     = 0;
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
